// ===== hdl/tnu_pkg.sv =====
package tnu_pkg;

   // port field width and fixed scaling of the cross product
   localparam int FIELD_W     = 16;
   localparam int SCALE_BITS  = 30;
   localparam int SQ_W        = 2 * SCALE_BITS;
   localparam int SUM_W       = SQ_W + 2;
   localparam int ROOT_STEPS  = SUM_W / 2;
   localparam int ROOT_W      = SCALE_BITS + 1;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // one scaled cross product, as it travels from front to back
   typedef struct packed {
      logic                            degen;
      logic [2:0]                      neg;
      logic [2:0][SCALE_BITS-1:0]      mag;
   } tnu_entry_type;

   // queue status seen by the front and the back
   typedef struct packed {
      logic full;
      logic nonempty;
   } tnu_qstat_type;

endpackage

// ===== hdl/triangle_normal_unit.sv =====
// channel  dir  handshake              payload
// req      in   req_valid/req_stall    first_*, middle_*, last_* (x,y,z), 16 bits each
// rsp      out  rsp_valid/rsp_stall    normal_x/y/z (16 bits), degenerate
//
// one triangle per cycle sustained while neither req_stall nor rsp_stall holds the flow; every stage is pipelined
// stages: the front stages, queue, then 2 square and sum stages, 31 square root stages,
// one divider setup stage, NORMAL_FRAC_BITS + 1 divider stages and the result register
// reset clears only the valid bits and the queue pointers and fill count
// a stalled result freezes the back pipeline; the four-entry queue keeps
// the front taking beats until it fills and the last front stage holds a beat, then req_stall rises
module triangle_normal_unit #(
   parameter int COORD_WIDTH      = 16,
   parameter int NORMAL_FRAC_BITS = 14
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [tnu_pkg::FIELD_W-1:0]   req_first_x,
   input  logic [tnu_pkg::FIELD_W-1:0]   req_first_y,
   input  logic [tnu_pkg::FIELD_W-1:0]   req_first_z,
   input  logic [tnu_pkg::FIELD_W-1:0]   req_middle_x,
   input  logic [tnu_pkg::FIELD_W-1:0]   req_middle_y,
   input  logic [tnu_pkg::FIELD_W-1:0]   req_middle_z,
   input  logic [tnu_pkg::FIELD_W-1:0]   req_last_x,
   input  logic [tnu_pkg::FIELD_W-1:0]   req_last_y,
   input  logic [tnu_pkg::FIELD_W-1:0]   req_last_z,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tnu_pkg::FIELD_W-1:0]   rsp_normal_x,
   output logic [tnu_pkg::FIELD_W-1:0]   rsp_normal_y,
   output logic [tnu_pkg::FIELD_W-1:0]   rsp_normal_z,
   output logic                          rsp_degenerate
);
   import tnu_pkg::*;

   logic [8:0][FIELD_W-1:0]   coords;
   logic                      push, pop;
   tnu_entry_type             wr_entry, rd_entry;
   tnu_qstat_type             qstat;
   logic [2:0][FIELD_W-1:0]   normal;

   assign coords = {req_last_z, req_last_y, req_last_x,
                    req_middle_z, req_middle_y, req_middle_x,
                    req_first_z, req_first_y, req_first_x};

   assign rsp_normal_x = normal[0];
   assign rsp_normal_y = normal[1];
   assign rsp_normal_z = normal[2];

   // cross product and block scaling
   tnu_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .coords    (coords),
      .qstat     (qstat),
      .push      (push),
      .entry     (wr_entry)
   );

   // decoupling queue
   tnu_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .wr_entry (wr_entry),
      .pop      (pop),
      .rd_entry (rd_entry),
      .qstat    (qstat)
   );

   // magnitude and normalization
   tnu_back #(.NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .qstat      (qstat),
      .head       (rd_entry),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .normal     (normal),
      .degenerate (rsp_degenerate)
   );

endmodule

// ===== hdl/tnu_front.sv =====
module tnu_front #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [8:0][tnu_pkg::FIELD_W-1:0]       coords,
   input  tnu_pkg::tnu_qstat_type                 qstat,
   output logic                                   push,
   output tnu_pkg::tnu_entry_type                 entry
);
   import tnu_pkg::*;

   localparam int W  = COORD_WIDTH;
   localparam int PW = 2 * W + 2;
   localparam int CW = 2 * W + 3;
   localparam int LW = $clog2(CW + 1);
   localparam int NFS = 6;

   logic                  fadv;
   logic [NFS-1:0]        fv_ff;

   logic signed [W-1:0]   p [9];
   logic signed [W:0]     u_in [3], v_in [3], u_ff [3], v_ff [3];
   logic signed [PW-1:0]  pr_in [6], pr_ff [6];
   logic signed [CW-1:0]  cr_in [3], cr_ff [3];
   logic [CW-1:0]         mg_in [3], mg_ff [3], mg5_ff [3];
   logic [2:0]            ng_ff, ng5_ff;
   logic [CW-1:0]         orw_ff;
   logic                  dg5_ff;
   logic [LW-1:0]         len_in, sh_in, sh_ff;
   tnu_entry_type         ent_in, ent_ff;

   // front advances unless its last beat is blocked by a full queue
   assign fadv      = !fv_ff[NFS-1] || !qstat.full;
   assign req_stall = !fadv;
   assign push      = fv_ff[NFS-1] && !qstat.full;
   assign entry     = ent_ff;

   // edge vectors from the middle vertex
   always_comb begin
      for (int i = 0; i < 9; i++) begin
         p[i] = $signed(W'(coords[i]));
      end
      for (int k = 0; k < 3; k++) begin
         u_in[k] = (W+1)'(p[6+k]) - (W+1)'(p[3+k]);
         v_in[k] = (W+1)'(p[k]) - (W+1)'(p[3+k]);
      end
   end

   // partial products of the cross product, its components and their magnitudes
   always_comb begin
      pr_in[0] = PW'(u_ff[1]) * PW'(v_ff[2]);
      pr_in[1] = PW'(u_ff[2]) * PW'(v_ff[1]);
      pr_in[2] = PW'(u_ff[2]) * PW'(v_ff[0]);
      pr_in[3] = PW'(u_ff[0]) * PW'(v_ff[2]);
      pr_in[4] = PW'(u_ff[0]) * PW'(v_ff[1]);
      pr_in[5] = PW'(u_ff[1]) * PW'(v_ff[0]);
      for (int k = 0; k < 3; k++) begin
         cr_in[k] = CW'(pr_ff[2*k]) - CW'(pr_ff[2*k+1]);
         mg_in[k] = cr_ff[k][CW-1] ? CW'(-cr_ff[k]) : CW'(cr_ff[k]);
      end
   end

   // bit length of the largest magnitude, then the block shift
   always_comb begin
      len_in = '0;
      for (int i = 0; i < CW; i++) begin
         if (orw_ff[i]) begin
            len_in = LW'(i + 1);
         end
      end
      if (int'(len_in) > SCALE_BITS) begin
         sh_in = LW'(int'(len_in) - SCALE_BITS);
      end else begin
         sh_in = '0;
      end
      ent_in.degen = dg5_ff;
      ent_in.neg   = ng5_ff;
      for (int k = 0; k < 3; k++) begin
         ent_in.mag[k] = SCALE_BITS'(mg5_ff[k] >> sh_ff);
      end
   end

   // valid bits of the front stages
   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= '0;
      end else if (fadv) begin
         fv_ff <= {fv_ff[NFS-2:0], req_valid};
      end
   end

   // front payload stages
   always_ff @(posedge clock) begin
      if (fadv) begin
         u_ff   <= u_in;
         v_ff   <= v_in;
         pr_ff  <= pr_in;
         cr_ff  <= cr_in;
         mg_ff  <= mg_in;
         orw_ff <= mg_in[0] | mg_in[1] | mg_in[2];
         for (int k = 0; k < 3; k++) begin
            ng_ff[k] <= cr_ff[k][CW-1];
         end
         mg5_ff <= mg_ff;
         ng5_ff <= ng_ff;
         dg5_ff <= (orw_ff == '0);
         sh_ff  <= sh_in;
         ent_ff <= ent_in;
      end
   end

endmodule

// ===== hdl/tnu_queue.sv =====
module tnu_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  tnu_pkg::tnu_entry_type   wr_entry,
   input  logic                     pop,
   output tnu_pkg::tnu_entry_type   rd_entry,
   output tnu_pkg::tnu_qstat_type   qstat
);
   import tnu_pkg::*;

   tnu_entry_type       mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wp_ff, rp_ff;
   logic [QCNT_W-1:0]   cnt_ff;
   logic                do_push, do_pop;

   assign qstat.full     = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign qstat.nonempty = (cnt_ff != '0);
   assign do_push        = push && !qstat.full;
   assign do_pop         = pop && qstat.nonempty;
   assign rd_entry       = mem_ff[rp_ff];

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) begin
            wp_ff <= wp_ff + 1'b1;
         end
         if (do_pop) begin
            rp_ff <= rp_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wp_ff] <= wr_entry;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_fill: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop && cnt_ff == QCNT_W'(QUEUE_DEPTH - 1)) |=> qstat.full)
      else $error("queue not full after last slot taken");

endmodule

// ===== hdl/tnu_back.sv =====
module tnu_back #(
   parameter int NORMAL_FRAC_BITS = 14
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tnu_pkg::tnu_qstat_type              qstat,
   input  tnu_pkg::tnu_entry_type              head,
   output logic                                pop,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [2:0][tnu_pkg::FIELD_W-1:0]    normal,
   output logic                                degenerate
);
   import tnu_pkg::*;

   localparam int F   = NORMAL_FRAC_BITS;
   localparam int QB  = F + 1;
   localparam int NW  = SCALE_BITS + 1 + F;
   localparam int RW  = SUM_W + 1;
   localparam int NST = 2 + ROOT_STEPS + 1 + QB + 1;

   logic                   adv;
   logic [NST-1:0]         pv_ff;

   logic [SQ_W-1:0]        sq_ff [3];
   tnu_entry_type          e1_ff, e2_ff;
   logic [SUM_W-1:0]       sum_ff;

   logic [RW-1:0]          rn_in [ROOT_STEPS], rr_in [ROOT_STEPS];
   logic [RW-1:0]          rn_ff [ROOT_STEPS], rr_ff [ROOT_STEPS];
   tnu_entry_type          re_ff [ROOT_STEPS];

   logic [ROOT_W-1:0]      mag_in;
   logic [NW-1:0]          num_in [3];
   logic [ROOT_W-1:0]      dm_ff [QB+1];
   logic [ROOT_W-1:0]      drem_in [QB+1][3], drem_ff [QB+1][3];
   logic [QB-1:0]          dlow_in [QB+1][3], dlow_ff [QB+1][3];
   logic [QB-1:0]          dq_in [QB+1][3], dq_ff [QB+1][3];
   tnu_entry_type          de_ff [QB+1];

   logic [QB-1:0]          qc;
   logic signed [QB:0]     sv;
   logic [2:0][FIELD_W-1:0] nrm_in, nrm_ff;
   logic                   dg_ff;

   // whole back pipeline moves when the result register can take a beat
   assign adv        = !pv_ff[NST-1] || !rsp_stall;
   assign pop        = adv && qstat.nonempty;
   assign rsp_valid  = pv_ff[NST-1];
   assign normal     = nrm_ff;
   assign degenerate = dg_ff;

   // integer square root, two radicand bits and one result bit per stage
   always_comb begin
      for (int k = 0; k < ROOT_STEPS; k++) begin
         logic [RW-1:0] n0, r0, bt, tr;
         n0 = (k == 0) ? RW'(sum_ff) : rn_ff[(k == 0) ? 0 : k-1];
         r0 = (k == 0) ? '0 : rr_ff[(k == 0) ? 0 : k-1];
         bt = RW'(1) << (SUM_W - 2 - 2*k);
         tr = r0 + bt;
         if (n0 >= tr) begin
            rn_in[k] = n0 - tr;
            rr_in[k] = (r0 >> 1) + bt;
         end else begin
            rn_in[k] = n0;
            rr_in[k] = r0 >> 1;
         end
      end
   end

   // divisor and rounded dividends, then restoring division one bit per stage
   always_comb begin
      mag_in = rr_ff[ROOT_STEPS-1][ROOT_W-1:0];
      if (mag_in == '0) begin
         mag_in = ROOT_W'(1);
      end
      for (int c = 0; c < 3; c++) begin
         num_in[c]     = (NW'(re_ff[ROOT_STEPS-1].mag[c]) << F) + NW'(mag_in >> 1);
         drem_in[0][c] = ROOT_W'(num_in[c][NW-1:QB]);
         dlow_in[0][c] = num_in[c][QB-1:0];
         dq_in[0][c]   = '0;
      end
      for (int j = 1; j <= QB; j++) begin
         for (int c = 0; c < 3; c++) begin
            logic [ROOT_W:0] tr;
            logic            ge;
            tr = {drem_ff[j-1][c], dlow_ff[j-1][c][QB-1]};
            ge = (tr >= {1'b0, dm_ff[j-1]});
            drem_in[j][c] = ge ? ROOT_W'(tr - {1'b0, dm_ff[j-1]}) : ROOT_W'(tr);
            dlow_in[j][c] = dlow_ff[j-1][c] << 1;
            dq_in[j][c]   = {dq_ff[j-1][c][QB-2:0], ge};
         end
      end
   end

   // clamp, restore sign and wrap to the port width
   always_comb begin
      qc = '0;
      sv = '0;
      for (int c = 0; c < 3; c++) begin
         qc = dq_ff[QB][c];
         if (qc > QB'(1) << F) begin
            qc = QB'(1) << F;
         end
         sv = de_ff[QB].neg[c] ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
         nrm_in[c] = FIELD_W'(sv);
      end
   end

   // valid bits of the back stages
   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= '0;
      end else if (adv) begin
         pv_ff <= {pv_ff[NST-2:0], qstat.nonempty};
      end
   end

   // back payload stages
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int c = 0; c < 3; c++) begin
            sq_ff[c] <= SQ_W'(head.mag[c]) * SQ_W'(head.mag[c]);
         end
         e1_ff  <= head;
         sum_ff <= SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);
         e2_ff  <= e1_ff;
         for (int k = 0; k < ROOT_STEPS; k++) begin
            rn_ff[k] <= rn_in[k];
            rr_ff[k] <= rr_in[k];
            re_ff[k] <= (k == 0) ? e2_ff : re_ff[(k == 0) ? 0 : k-1];
         end
         dm_ff[0] <= mag_in;
         de_ff[0] <= re_ff[ROOT_STEPS-1];
         for (int j = 1; j <= QB; j++) begin
            dm_ff[j] <= dm_ff[j-1];
            de_ff[j] <= de_ff[j-1];
         end
         drem_ff <= drem_in;
         dlow_ff <= dlow_in;
         dq_ff   <= dq_in;
         nrm_ff  <= nrm_in;
         dg_ff   <= de_ff[QB].degen;
      end
   end

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && degenerate) |->
         (normal[0] == '0 && normal[1] == '0 && normal[2] == '0))
      else $error("degenerate result with nonzero normal");

   a_pop_moves: assert property (@(posedge clock) disable iff (reset)
      pop |=> pv_ff[0])
      else $error("popped entry lost in back pipeline");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import tnu_pkg::*;

   localparam int FRAC_BITS  = 14;
   localparam int RUN_LIMIT  = 400000;
   localparam int DRAIN_WAIT = 80;

   typedef struct {
      logic [FIELD_W-1:0] v[9];
   } triangle_type;

   typedef struct {
      logic [FIELD_W-1:0] nx, ny, nz;
      logic               degen;
   } normal_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [FIELD_W-1:0] req_field[9];
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [FIELD_W-1:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic rsp_degenerate;

   triangle_type pending_tris[$];
   normal_type   expected_normals[$];
   int  mismatches = 0;
   int  cycle_count = 0;
   int  tris_sent = 0;
   int  normals_seen = 0;
   int  degen_seen = 0;
   int  send_idle_pct = 0;
   int  stall_pct = 0;
   int  hold_off = 0;
   bit  send_pause = 0;
   bit  req_taken = 0;

   initial begin
      for (int i = 0; i < 9; i++) req_field[i] = '0;
   end

   triangle_normal_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_first_x(req_field[0]), .req_first_y(req_field[1]), .req_first_z(req_field[2]),
      .req_middle_x(req_field[3]), .req_middle_y(req_field[4]), .req_middle_z(req_field[5]),
      .req_last_x(req_field[6]), .req_last_y(req_field[7]), .req_last_z(req_field[8]),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_normal_x(rsp_normal_x), .rsp_normal_y(rsp_normal_y),
      .rsp_normal_z(rsp_normal_z), .rsp_degenerate(rsp_degenerate)
   );

   // clock
   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // bit-serial integer square root
   function automatic logic [63:0] root_of(logic [63:0] num);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > num) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (num >= res + bitv) begin
            num = num - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // unit face normal of one triangle
   function automatic normal_type face_normal(triangle_type t);
      normal_type r;
      longint p[9];
      longint u[3], w[3], c[3];
      logic [63:0] a[3], m, sum, mag, q;
      int s;
      for (int i = 0; i < 9; i++) p[i] = longint'(signed'(t.v[i]));
      for (int i = 0; i < 3; i++) begin
         u[i] = p[6+i] - p[3+i];
         w[i] = p[i] - p[3+i];
      end
      c[0] = u[1]*w[2] - u[2]*w[1];
      c[1] = u[2]*w[0] - u[0]*w[2];
      c[2] = u[0]*w[1] - u[1]*w[0];
      r.nx = 0; r.ny = 0; r.nz = 0; r.degen = 1;
      if (c[0] == 0 && c[1] == 0 && c[2] == 0) return r;
      m = 0;
      for (int i = 0; i < 3; i++) begin
         a[i] = c[i] < 0 ? -c[i] : c[i];
         if (a[i] > m) m = a[i];
      end
      s = 0;
      while ((m >> s) >= (64'd1 << 30)) s++;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         a[i] = a[i] >> s;
         sum += a[i] * a[i];
      end
      mag = root_of(sum);
      if (mag == 0) mag = 1;
      for (int i = 0; i < 3; i++) begin
         q = ((a[i] << FRAC_BITS) + (mag >> 1)) / mag;
         if (q > (64'd1 << FRAC_BITS)) q = 64'd1 << FRAC_BITS;
         if (c[i] < 0) q = -q;
         a[i] = q;
      end
      r.nx = a[0][15:0]; r.ny = a[1][15:0]; r.nz = a[2][15:0]; r.degen = 0;
      return r;
   endfunction

   // input beat taken at the rising edge
   always @(posedge clock) begin
      req_taken <= req_valid && !req_stall;
   end

   // driver: offer pending triangles at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else if (!req_valid || req_taken) begin
         if (req_valid) begin
            expected_normals.push_back(face_normal(pending_tris.pop_front()));
            tris_sent++;
         end
         if (pending_tris.size() > 0 && !send_pause &&
             $urandom_range(99) >= send_idle_pct) begin
            for (int i = 0; i < 9; i++) req_field[i] <= pending_tris[0].v[i];
            req_valid <= 1;
         end else begin
            req_valid <= 0;
         end
      end
   end

   // receiver stall, with long hold-offs counted here
   always @(negedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // monitor: compare each result beat with the oldest prediction
   always @(posedge clock) begin
      normal_type e;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         normals_seen++;
         if (rsp_degenerate) degen_seen++;
         if (expected_normals.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat");
         end else begin
            e = expected_normals.pop_front();
            if (e.nx !== rsp_normal_x || e.ny !== rsp_normal_y ||
                e.nz !== rsp_normal_z || e.degen !== rsp_degenerate) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %h %h %h %b got %h %h %h %b",
                           e.nx, e.ny, e.nz, e.degen, rsp_normal_x,
                           rsp_normal_y, rsp_normal_z, rsp_degenerate);
            end
         end
      end
   end

   // timeout
   always @(posedge clock) begin
      if (cycle_count > RUN_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic logic [FIELD_W-1:0] rand_coord(int mode);
      case (mode)
         0: return FIELD_W'($urandom);
         1: return FIELD_W'($urandom_range(15) - 8);
         2: return $urandom_range(1) ? 16'h7fff : 16'h8000;
         default: return FIELD_W'($urandom_range(2047) - 1024);
      endcase
   endfunction

   task automatic add_tri(input logic [FIELD_W-1:0] f[9]);
      triangle_type t;
      for (int i = 0; i < 9; i++) t.v[i] = f[i];
      pending_tris.push_back(t);
   endtask

   task automatic wait_drained();
      while (pending_tris.size() > 0 || req_valid || expected_normals.size() > 0)
         @(posedge clock);
   endtask

   // stimulus
   initial begin
      logic [FIELD_W-1:0] f[9];
      int mode;
      repeat (2) @(posedge clock);
      reset <= 0;

      // directed: unit axes, coincident, collinear, extremes
      f = '{0, 16'h0100, 0, 0, 0, 0, 16'h0100, 0, 0};
      add_tri(f);
      f = '{16'h0100, 0, 0, 0, 0, 0, 0, 16'h0100, 0};
      add_tri(f);
      f = '{0, 0, 16'h0100, 0, 0, 0, 16'h0100, 0, 0};
      add_tri(f);
      f = '{5, 5, 5, 5, 5, 5, 5, 5, 5};
      add_tri(f);
      f = '{1, 2, 3, 2, 4, 6, 3, 6, 9};
      add_tri(f);
      f = '{16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
            16'h7fff, 16'h7fff, 16'h8000};
      add_tri(f);
      f = '{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000,
            16'h8000, 16'h7fff, 16'h8000};
      add_tri(f);
      f = '{16'hffff, 0, 0, 0, 0, 0, 0, 16'hffff, 0};
      add_tri(f);
      f = '{16'h7fff, 16'h7fff, 16'h7fff, 0, 0, 0, 16'h8000, 16'h8000, 16'h8000};
      add_tri(f);
      f = '{16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
            16'hffff, 16'hffff, 16'hffff};
      add_tri(f);
      f = '{1, 0, 0, 0, 0, 0, 0, 1, 0};
      add_tri(f);
      f = '{16'h7fff, 0, 0, 16'h8000, 0, 0, 16'h8000, 16'h7fff, 0};
      add_tri(f);
      wait_drained();

      // random phases with varied idling and stalls
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1 || ph == 3) ? (ph == 3 ? 13 : 49) : 0;
         stall_pct     = (ph == 2 || ph == 3) ? (ph == 3 ? 13 : 49) : 0;
         for (int n = 0; n < 420; n++) begin
            mode = $urandom_range(5);
            for (int i = 0; i < 9; i++) f[i] = rand_coord(mode);
            // occasional collinear triangle
            if ($urandom_range(19) == 0)
               for (int i = 0; i < 3; i++) f[6+i] = f[3+i] + (f[3+i] - f[i]);
            add_tri(f);
         end
         if (ph == 1) begin
            hold_off = 300;
         end
         // pause the sender until everything is back
         wait (pending_tris.size() < 200);
         send_pause = 1;
         while (req_valid || expected_normals.size() > 0) @(posedge clock);
         send_pause = 0;
         wait_drained();
      end

      repeat (DRAIN_WAIT) @(posedge clock);
      $display("sent %0d triangles, checked %0d normals (%0d degenerate)",
               tris_sent, normals_seen, degen_seen);
      if (mismatches == 0 && expected_normals.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
